// ----- design/ohash_pkg.sv -----
// Package for the open-addressed hash table.
// Holds the sequencer state type, slot tag codes and request mode codes.
// No dependencies.
package ohash_pkg;

  localparam int TAG_W = 2;

  localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
  localparam logic [TAG_W-1:0] TAG_LIVE  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_DEAD  = 2'd2;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_Q,
    ST_DIV_D,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_WRITE,
    ST_FINISH
  } state_t;

endpackage

// ----- design/open_addressed_hash_table.sv -----
// Open-addressed key/value table with tombstones; uses ohash_pkg, ohash_div, ohash_ram.
// Each request runs the two divisions, then the probe walk, then the write back
// and the result register; a clear instead sweeps the tag memory. One request
// is taken at a time, set by the bit-serial divider and the one read port of the
// slot memories. After reset the tag memory is swept empty, one slot a cycle
// over all SLOTS slots, while no request is accepted.
module open_addressed_hash_table #(
  parameter int SLOTS    = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [9:0]                   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic [KEY_BITS-1:0]          key,
  input  logic [31:0]                  value,
  input  logic [31:0]                  default_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [31:0]                  value_out,
  output logic                         status,
  output logic [$clog2(SLOTS+1)-1:0]   live_count,
  output logic                         needs_growth
);

  import ohash_pkg::*;

  localparam int AW   = $clog2(SLOTS);
  localparam int SW   = AW + 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (SW > 10) ? SW : 10;
  localparam int GW   = ((CW > SW) ? CW : SW) + 4;
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

  // Configuration and the effective size, clamped to the range 3..SLOTS.
  logic [9:0]  table_size;
  logic [SW-1:0] s_eff;
  logic [CMPW-1:0] ts_wide;

  assign ts_wide = CMPW'(table_size);
  always_comb begin
    if (ts_wide < CMPW'(3)) begin
      s_eff = SW'(3);
    end else if (ts_wide > CMPW'(SLOTS)) begin
      s_eff = SW'(SLOTS);
    end else begin
      s_eff = ts_wide[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= 10'd17;
    end else if (cfg_we) begin
      table_size <= cfg_data;
    end
  end

  // Sequencer and request registers.
  state_t state, state_next;
  logic   accept;
  logic [1:0]          mode_q;
  logic [KEY_BITS-1:0] key_q;
  logic [31:0]         value_q;
  logic [31:0]         dflt_q;
  logic                clr_op;
  logic [AW-1:0]       clr_ctr;

  // Probe walk registers.
  logic [AW-1:0] h;
  logic [SW-1:0] d;
  logic [SW-1:0] probe_i;
  logic          fd_valid;
  logic [AW-1:0] fd;
  logic          hit;
  logic          gap_ok;
  logic          gap_empty;
  logic [AW-1:0] target;

  // Counters and the result held before the output register.
  logic [CW-1:0] entry_count;
  logic [CW-1:0] used_count;
  logic          res_found;
  logic [31:0]   res_vout;
  logic          res_status;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // The one divider serves both key mod S and (key / S) mod S.
  logic                div_start;
  logic                div_done;
  logic [KEY_BITS-1:0] div_quot;
  logic [SW-1:0]       div_rem;
  logic [KEY_BITS-1:0] div_dividend;

  assign div_start = (accept && mode != MODE_CLEAR) || (state == ST_DIV_Q && div_done);
  assign div_dividend = (state == ST_IDLE) ? key : div_quot;

  ohash_div #(.NW(KEY_BITS), .DW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (s_eff),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Slot memories. Tags are cleared by a sweep; keys and values need none.
  logic                tag_we, key_we, val_we;
  logic [AW-1:0]       wr_addr;
  logic [TAG_W-1:0]    tag_wdata;
  logic [TAG_W-1:0]    tag_rd;
  logic [KEY_BITS-1:0] key_rd;
  logic [31:0]         val_rd;

  ohash_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag (
    .clk (clk), .we (tag_we), .waddr (wr_addr), .wdata (tag_wdata),
    .raddr (h), .rdata (tag_rd)
  );
  ohash_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key (
    .clk (clk), .we (key_we), .waddr (wr_addr), .wdata (key_q),
    .raddr (h), .rdata (key_rd)
  );
  ohash_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_val (
    .clk (clk), .we (val_we), .waddr (wr_addr), .wdata (value_q),
    .raddr (h), .rdata (val_rd)
  );

  // Probe evaluation. The next slot is h + step, brought back below S with one
  // subtract, since both terms are already below S.
  logic          is_empty, is_dead, is_hit, is_last;
  logic [AW+1:0] step_sum;
  logic [AW-1:0] h_step;
  logic          fd_valid_n;
  logic [AW-1:0] fd_n;

  assign is_empty = (tag_rd == TAG_EMPTY);
  assign is_dead  = (tag_rd == TAG_DEAD);
  assign is_hit   = (tag_rd == TAG_LIVE) && (key_rd == key_q);
  assign is_last  = (probe_i == s_eff);

  always_comb begin
    if (probe_i == '0) begin
      step_sum = (AW+2)'(h) + (AW+2)'(d);
    end else begin
      step_sum = (AW+2)'(h) + (AW+2)'(2);
    end
    if (step_sum >= (AW+2)'(s_eff)) begin
      h_step = AW'(step_sum - (AW+2)'(s_eff));
    end else begin
      h_step = step_sum[AW-1:0];
    end
    fd_valid_n = fd_valid || is_dead;
    fd_n       = fd_valid ? fd : h;
  end

  // A remove that hits, or an insert that hits or finds a free slot, changes the memories.
  logic ins_new, rem_hit;
  assign ins_new = (mode_q == MODE_INSERT) && !hit && gap_ok;
  assign rem_hit = (mode_q == MODE_REMOVE) && hit;

  always_comb begin
    state_next = state;
    tag_we     = 1'b0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    wr_addr    = target;
    tag_wdata  = TAG_LIVE;
    unique case (state)
      ST_CLEAR: begin
        tag_we    = 1'b1;
        wr_addr   = clr_ctr;
        tag_wdata = TAG_EMPTY;
        if (clr_ctr == LAST_SLOT) begin
          state_next = clr_op ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (mode == MODE_CLEAR) ? ST_CLEAR : ST_DIV_Q;
        end
      end
      ST_DIV_Q: begin
        if (div_done) begin
          state_next = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        if (div_done) begin
          state_next = ST_PROBE_RD;
        end
      end
      ST_PROBE_RD: begin
        state_next = ST_PROBE_CHK;
      end
      ST_PROBE_CHK: begin
        if (is_empty || is_hit || is_last) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_PROBE_RD;
        end
      end
      ST_WRITE: begin
        if (ins_new) begin
          tag_we = 1'b1;
          key_we = 1'b1;
          val_we = 1'b1;
        end else if ((mode_q == MODE_INSERT) && hit) begin
          val_we = 1'b1;
        end else if (rem_hit) begin
          tag_we    = 1'b1;
          tag_wdata = TAG_DEAD;
        end
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ctr     <= '0;
      clr_op      <= 1'b0;
      entry_count <= '0;
      used_count  <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_ctr <= clr_ctr + 1'b1;
      end
      if (accept) begin
        clr_op <= (mode == MODE_CLEAR);
        if (mode == MODE_CLEAR) begin
          clr_ctr     <= '0;
          entry_count <= '0;
          used_count  <= '0;
        end
      end
      if (state == ST_WRITE) begin
        if (ins_new) begin
          entry_count <= entry_count + 1'b1;
          if (gap_empty) begin
            used_count <= used_count + 1'b1;
          end
        end else if (rem_hit && entry_count != '0) begin
          entry_count <= entry_count - 1'b1;
        end
      end
    end
  end

  // Request capture, probe walk and result.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode;
      key_q   <= key;
      value_q <= value;
      dflt_q  <= default_value;
    end
    if (state == ST_DIV_Q && div_done) begin
      h <= div_rem[AW-1:0];
    end
    if (state == ST_DIV_D && div_done) begin
      d        <= (div_rem == '0) ? SW'(1) : div_rem;
      probe_i  <= '0;
      fd_valid <= 1'b0;
    end
    if (state == ST_PROBE_CHK) begin
      if (is_empty) begin
        hit       <= 1'b0;
        gap_ok    <= 1'b1;
        gap_empty <= !fd_valid;
        target    <= fd_n;
      end else if (is_hit) begin
        hit    <= 1'b1;
        target <= h;
      end else begin
        fd_valid <= fd_valid_n;
        fd       <= fd_n;
        if (is_last) begin
          hit       <= 1'b0;
          gap_ok    <= fd_valid_n;
          gap_empty <= 1'b0;
          target    <= fd_n;
        end else begin
          h       <= h_step;
          probe_i <= probe_i + 1'b1;
        end
      end
    end
    if (accept && mode == MODE_CLEAR) begin
      res_found  <= 1'b0;
      res_vout   <= default_value;
      res_status <= 1'b0;
    end
    if (state == ST_WRITE) begin
      res_found  <= hit;
      res_vout   <= (hit && mode_q == MODE_LOOKUP) ? val_rd : dflt_q;
      res_status <= (mode_q == MODE_INSERT) && !hit && !gap_ok;
    end
  end

  // Output register. Growth is flagged when used * 10 > S * 8, kept as 5 and 4.
  logic [GW-1:0] used_x5, size_x4;
  assign used_x5 = GW'(used_count) * GW'(5);
  assign size_x4 = GW'(s_eff) * GW'(4);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!out_valid || !out_stall)) begin
      found        <= res_found;
      value_out    <= res_vout;
      status       <= res_status;
      live_count   <= entry_count;
      needs_growth <= (used_x5 > size_x4);
    end
  end

  // Checks on the sequencer and counters.
  a_live_le_used: assert property (@(posedge clk) disable iff (rst)
    entry_count <= used_count)
    else $error("live entries exceed used slots");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(SLOTS))
    else $error("used slot count beyond table capacity");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_PROBE_CHK |-> probe_i <= s_eff)
    else $error("probe walk ran past S+1 probes");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("request accepted before the tag sweep");

endmodule

// ----- design/ohash_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ohash_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ohash_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Gives quotient and remainder of an unsigned dividend by an unsigned divisor.
// No dependencies.
module ohash_div #(
  parameter int NW = 32,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CNTW = (NW > 1) ? $clog2(NW) : 1;
  localparam logic [CNTW-1:0] LAST = CNTW'(NW - 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     trial;
  logic            take;

  assign trial = {rem, quot[NW-1]};
  assign take  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[NW-2:0], take};
      rem  <= take ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
    end
  end

endmodule
